@@ hdl/wrms_pkg.sv @@
package wrms_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SQ_W     = 31;
    localparam int CFG_W    = 11;
    localparam int LEVEL_W  = 16;

    localparam logic [CFG_W-1:0]   FRAME_SAMPLES_RESET = CFG_W'(480);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX           = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_ADD,
        S_DIV,
        S_SQRT,
        S_OUT
    } t_state;

endpackage

@@ hdl/windowed_rms_level_meter_core.sv @@
// channel   | direction | handshake                | payload
// ----------+-----------+--------------------------+----------------------------------
// input     | in        | i_in_valid / o_in_ready  | i_sample, i_last_in_frame
// output    | out       | o_out_valid / i_out_ready| o_level
// config    | in        | i_cfg_we (no wait)       | i_cfg_wdata (frame_samples)
//
// a sample without the last-in-frame mark is taken every cycle, also while a level is worked out
// a sample with the mark starts the back end: window read, sum update, a radix-2 divider
// and a bit-pair root; another marked sample is held off until the back end is free
// the back end also waits in its last state while the output register still holds a level
// reset clears the accumulator, the window valid bits, position, sum and the output valid flag
module windowed_rms_level_meter_core #(
    parameter int WINDOW            = 16,
    parameter int MAX_FRAME_SAMPLES = 2048
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [wrms_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [wrms_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                 i_last_in_frame,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [wrms_pkg::LEVEL_W-1:0]         o_level
);

    localparam int ACC_W = $clog2(MAX_FRAME_SAMPLES) + 30;
    localparam int SUM_W = ACC_W + $clog2(WINDOW);
    localparam int WIN_W = $clog2(WINDOW + 1);
    localparam int DIV_W = wrms_pkg::CFG_W + WIN_W;
    localparam int R_W   = (SUM_W + 1) / 2;
    localparam int RAD_W = 2 * R_W;
    localparam int SR_W  = R_W + 2;
    localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(SUM_W + 1);
    localparam logic [ACC_W:0] ACC_LIM = (ACC_W + 1)'(MAX_FRAME_SAMPLES) << 30;

    // window store
    logic [ACC_W-1:0] r_mem [WINDOW];
    logic [ACC_W-1:0] r_rd_data;
    logic             mem_re;
    logic             mem_we;

    wrms_pkg::t_state r_state, n_state;
    logic [wrms_pkg::CFG_W-1:0] r_frame_samples, n_frame_samples;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [WINDOW-1:0] r_valid, n_valid;
    logic              r_rd_valid, n_rd_valid;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;

    logic [ACC_W-1:0]  r_energy, n_energy;
    logic [DIV_W-1:0]  r_den, n_den;
    logic [SUM_W-1:0]  r_quo, n_quo;
    logic [DIV_W-1:0]  r_rem, n_rem;
    logic [RAD_W-1:0]  r_rad, n_rad;
    logic [R_W-1:0]    r_root, n_root;
    logic [SR_W-1:0]   r_srem, n_srem;
    logic [wrms_pkg::LEVEL_W-1:0] r_level, n_level;

    logic signed [2*wrms_pkg::SAMPLE_W-1:0] sq_full;
    logic [ACC_W:0]    acc_add;
    logic [ACC_W-1:0]  acc_sat;
    logic              in_acc;
    logic [wrms_pkg::CFG_W-1:0] n_eff;
    logic [DIV_W:0]    div_sh;
    logic              div_ge;
    logic [DIV_W:0]    div_diff;
    logic [SR_W+1:0]   sq_sh;
    logic [SR_W+1:0]   sq_trial;
    logic              sq_ge;
    logic [SR_W+1:0]   sq_diff;

    assign o_in_ready  = (r_state == wrms_pkg::S_IDLE) || !i_last_in_frame;
    assign o_out_valid = r_out_valid;
    assign o_level     = r_level;
    assign in_acc      = i_in_valid && o_in_ready;

    always_comb begin
        sq_full = i_sample * i_sample;
        acc_add = {1'b0, r_acc} + (ACC_W + 1)'(sq_full[wrms_pkg::SQ_W-1:0]);
        if (acc_add >= ACC_LIM) begin
            acc_sat = ACC_W'(ACC_LIM - 1'b1);
        end else begin
            acc_sat = acc_add[ACC_W-1:0];
        end
        n_eff = (r_frame_samples == '0) ? wrms_pkg::CFG_W'(1) : r_frame_samples;

        // restoring divide step
        div_sh   = {r_rem, r_quo[SUM_W-1]};
        div_ge   = div_sh >= {1'b0, r_den};
        div_diff = div_sh - {1'b0, r_den};

        // bit-pair root step
        sq_sh    = {r_srem, r_rad[RAD_W-1 -: 2]};
        sq_trial = (SR_W + 2)'({r_root, 2'b01});
        sq_ge    = sq_sh >= sq_trial;
        sq_diff  = sq_sh - sq_trial;
    end

    always_comb begin
        n_state         = r_state;
        n_frame_samples = r_frame_samples;
        n_acc           = r_acc;
        n_sum           = r_sum;
        n_pos           = r_pos;
        n_valid         = r_valid;
        n_rd_valid      = r_rd_valid;
        n_cnt           = r_cnt;
        n_out_valid     = r_out_valid;
        n_energy        = r_energy;
        n_den           = r_den;
        n_quo           = r_quo;
        n_rem           = r_rem;
        n_rad           = r_rad;
        n_root          = r_root;
        n_srem          = r_srem;
        n_level         = r_level;
        mem_re          = 1'b0;
        mem_we          = 1'b0;

        if (i_cfg_we) begin
            n_frame_samples = i_cfg_wdata;
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (in_acc) begin
            if (i_last_in_frame) begin
                n_energy   = acc_sat;
                n_acc      = '0;
                n_den      = DIV_W'(n_eff) * DIV_W'(WINDOW);
                n_rd_valid = r_valid[r_pos];
                mem_re     = 1'b1;
            end else begin
                n_acc = acc_sat;
            end
        end

        case (r_state)
            wrms_pkg::S_IDLE: begin
                if (in_acc && i_last_in_frame) begin
                    n_state = wrms_pkg::S_READ;
                end
            end
            wrms_pkg::S_READ: begin
                // drop the oldest energy and store the new one in its place
                n_sum          = r_sum - (r_rd_valid ? SUM_W'(r_rd_data) : '0);
                mem_we         = 1'b1;
                n_valid[r_pos] = 1'b1;
                n_pos          = (r_pos == POS_W'(WINDOW - 1)) ? '0 : r_pos + 1'b1;
                n_state        = wrms_pkg::S_ADD;
            end
            wrms_pkg::S_ADD: begin
                n_sum   = r_sum + SUM_W'(r_energy);
                n_quo   = n_sum;
                n_rem   = '0;
                n_cnt   = '0;
                n_state = wrms_pkg::S_DIV;
            end
            wrms_pkg::S_DIV: begin
                n_quo = {r_quo[SUM_W-2:0], div_ge};
                n_rem = div_ge ? div_diff[DIV_W-1:0] : div_sh[DIV_W-1:0];
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SUM_W - 1)) begin
                    n_rad   = RAD_W'(n_quo);
                    n_root  = '0;
                    n_srem  = '0;
                    n_cnt   = '0;
                    n_state = wrms_pkg::S_SQRT;
                end
            end
            wrms_pkg::S_SQRT: begin
                n_rad  = {r_rad[RAD_W-3:0], 2'b00};
                n_root = {r_root[R_W-2:0], sq_ge};
                n_srem = sq_ge ? sq_diff[SR_W-1:0] : sq_sh[SR_W-1:0];
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(R_W - 1)) begin
                    n_state = wrms_pkg::S_OUT;
                end
            end
            wrms_pkg::S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    if (r_root[R_W-1:wrms_pkg::LEVEL_W] != '0) begin
                        n_level = wrms_pkg::LEVEL_MAX;
                    end else begin
                        n_level = r_root[wrms_pkg::LEVEL_W-1:0];
                    end
                    n_out_valid = 1'b1;
                    n_state     = wrms_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wrms_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= wrms_pkg::S_IDLE;
            r_frame_samples <= wrms_pkg::FRAME_SAMPLES_RESET;
            r_acc           <= '0;
            r_sum           <= '0;
            r_pos           <= '0;
            r_valid         <= '0;
            r_rd_valid      <= 1'b0;
            r_cnt           <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_frame_samples <= n_frame_samples;
            r_acc           <= n_acc;
            r_sum           <= n_sum;
            r_pos           <= n_pos;
            r_valid         <= n_valid;
            r_rd_valid      <= n_rd_valid;
            r_cnt           <= n_cnt;
            r_out_valid     <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_energy <= n_energy;
        r_den    <= n_den;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_rad    <= n_rad;
        r_root   <= n_root;
        r_srem   <= n_srem;
        r_level  <= n_level;
    end

    // entries never written read as zero through the valid bits
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_pos] <= r_energy;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[r_pos];
        end
    end

endmodule
